[rtl/rsi_pkg.sv]
// Shared types and constants for the relative strength index unit.
// No dependencies; used by relative_strength_index_unit.
package rsi_pkg;

    localparam int MAX_WINDOW_DEF = 64;
    localparam int PRICE_BITS_DEF = 32;

    localparam int WIN_W       = 7;
    localparam int RSI_W       = 23;
    localparam int QUO_CNT_W   = $clog2(RSI_W);

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(14);

    // 100 in Q7.16 is 6553600 = 2^22 + 2^21 + 2^18
    localparam int SCALE_SH_A = 22;
    localparam int SCALE_SH_B = 21;
    localparam int SCALE_SH_C = 18;
    localparam logic [RSI_W-1:0] SCALE_Q716  = RSI_W'(6553600);
    // 100 - 100/101 in Q7.16, truncated
    localparam logic [RSI_W-1:0] NO_LOSS_RSI = RSI_W'(6488712);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUB,
        ST_ADD,
        ST_CHECK,
        ST_PROD1,
        ST_PROD2,
        ST_DIV,
        ST_FINISH
    } rsi_state_t;

endpackage

[rtl/rsi_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rsi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/relative_strength_index_unit.sv]
// Relative strength index unit: sliding window of price changes in a RAM ring.
// Depends on rsi_pkg and rsi_ram.
//
// Each accepted price forms a change from the previous price; the change ring
// (one RAM with registered read data) holds the last N changes and running gain
// and loss sums are kept in registers. From the (N+1)th price since the last
// window write or reset, each price yields one beat: rsi_value =
// floor(100*gains/(gains+losses)) in unsigned Q7.16, or the fixed value 6488712
// with no_losses set when the loss sum is zero. The unit takes one price at a
// time: it accepts the next price only once it is back in idle. A computed
// result comes from the radix-2 restoring divider that yields one of 23 quotient
// bits per cycle, and a result also waits while the output register still holds
// the previous beat. A finished result waits in the output register while the
// next price is accepted. Writing window_length clears the history; a window of
// 0 acts as 1 and one above MAX_WINDOW as MAX_WINDOW.
module relative_strength_index_unit #(
    parameter int MAX_WINDOW = rsi_pkg::MAX_WINDOW_DEF,
    parameter int PRICE_BITS = rsi_pkg::PRICE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [PRICE_BITS-1:0]       price_sample,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rsi_pkg::RSI_W-1:0]   rsi_value,
    output logic                        no_losses,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rsi_pkg::WIN_W-1:0]   window_length
);

    localparam int WIN_MAXV = (1 << rsi_pkg::WIN_W) - 1;
    localparam int WIN_CAP  = (MAX_WINDOW < WIN_MAXV) ? MAX_WINDOW : WIN_MAXV;
    localparam int PTR_W    = $clog2(MAX_WINDOW);
    localparam int SEEN_W   = $clog2(WIN_CAP + 2);
    localparam int IDX_W    = (PTR_W + 1 > SEEN_W) ? PTR_W + 1 : SEEN_W;
    localparam int CH_W     = PRICE_BITS + 1;
    localparam int SUM_W    = PRICE_BITS + $clog2(WIN_CAP + 1);
    localparam int RSI_W    = rsi_pkg::RSI_W;
    localparam int PROD_W   = SUM_W + RSI_W;
    localparam int CNT_W    = rsi_pkg::QUO_CNT_W;

    rsi_pkg::rsi_state_t state_reg, state_next;

    logic [rsi_pkg::WIN_W-1:0] win_reg, win_next;
    logic [PRICE_BITS-1:0]     prev_reg, prev_next;
    logic [SUM_W-1:0]          gain_reg, gain_next;
    logic [SUM_W-1:0]          loss_reg, loss_next;
    logic [SEEN_W-1:0]         seen_reg, seen_next;
    logic [PTR_W-1:0]          ptr_reg, ptr_next;
    logic                      out_valid_reg, out_valid_next;

    logic [CH_W-1:0]           ch_reg, ch_next;
    logic [SUM_W-1:0]          div_reg, div_next;
    logic [PROD_W-1:0]         prod_reg, prod_next;
    logic [SUM_W-1:0]          rem_reg, rem_next;
    logic [RSI_W-1:0]          low_reg, low_next;
    logic [RSI_W-1:0]          quo_reg, quo_next;
    logic                      nl_reg, nl_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [RSI_W-1:0]          rsi_value_reg, rsi_value_next;
    logic                      no_losses_reg, no_losses_next;

    logic [IDX_W-1:0]          n_ext;
    logic [IDX_W-1:0]          ptr_ext;
    logic [IDX_W-1:0]          seen_ext;
    logic [PTR_W-1:0]          ptr_eff;
    logic                      in_acc;
    logic                      cfg_acc;
    logic                      ram_we;
    logic                      ram_re;
    logic [CH_W-1:0]           ram_rdata;
    logic [CH_W-1:0]           old_mag;
    logic [CH_W-1:0]           new_mag;
    logic [PROD_W-1:0]         prod_full;
    logic [SUM_W:0]            div_shift;
    logic                      div_ge;

    assign in_ready  = (state_reg == rsi_pkg::ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == rsi_pkg::ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign cfg_acc   = cfg_valid && cfg_ready;

    assign out_valid = out_valid_reg;
    assign rsi_value = rsi_value_reg;
    assign no_losses = no_losses_reg;

    // Effective window: zero acts as one, clamp to the ring depth
    always_comb
    begin
        if (win_reg == '0)
        begin
            n_ext = IDX_W'(1);
        end
        else if (IDX_W'(win_reg) > IDX_W'(WIN_CAP))
        begin
            n_ext = IDX_W'(WIN_CAP);
        end
        else
        begin
            n_ext = IDX_W'(win_reg);
        end
    end

    assign ptr_ext  = IDX_W'(ptr_reg);
    assign seen_ext = IDX_W'(seen_reg);
    assign ptr_eff  = (ptr_ext >= n_ext) ? '0 : ptr_reg;

    assign ram_re = in_acc;
    assign ram_we = (state_reg == rsi_pkg::ST_ADD);

    rsi_ram #(
        .WIDTH (CH_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (ch_reg),
        .re    (ram_re),
        .raddr (ptr_eff),
        .rdata (ram_rdata)
    );

    assign old_mag   = CH_W'(~ram_rdata + CH_W'(1));
    assign new_mag   = CH_W'(~ch_reg + CH_W'(1));
    assign prod_full = prod_reg + (PROD_W'(gain_reg) << rsi_pkg::SCALE_SH_C);
    assign div_shift = {rem_reg, low_reg[RSI_W-1]};
    assign div_ge    = (div_shift >= {1'b0, div_reg});

    always_comb
    begin
        state_next     = state_reg;
        win_next       = win_reg;
        prev_next      = prev_reg;
        gain_next      = gain_reg;
        loss_next      = loss_reg;
        seen_next      = seen_reg;
        ptr_next       = ptr_reg;
        out_valid_next = out_valid_reg;
        ch_next        = ch_reg;
        div_next       = div_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        low_next       = low_reg;
        quo_next       = quo_reg;
        nl_next        = nl_reg;
        cnt_next       = cnt_reg;
        rsi_value_next = rsi_value_reg;
        no_losses_next = no_losses_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            rsi_pkg::ST_IDLE:
            begin
                if (cfg_acc)
                begin
                    win_next  = window_length;
                    prev_next = '0;
                    gain_next = '0;
                    loss_next = '0;
                    seen_next = '0;
                    ptr_next  = '0;
                end
                else if (in_acc)
                begin
                    prev_next = price_sample;
                    if (seen_reg == '0)
                    begin
                        seen_next = SEEN_W'(1);
                    end
                    else
                    begin
                        ch_next    = {1'b0, price_sample} - {1'b0, prev_reg};
                        ptr_next   = ptr_eff;
                        state_next = rsi_pkg::ST_SUB;
                    end
                end
            end

            // Drop the oldest change once the window is full
            rsi_pkg::ST_SUB:
            begin
                if (seen_ext > n_ext)
                begin
                    if (ram_rdata[CH_W-1])
                    begin
                        loss_next = loss_reg - SUM_W'(old_mag);
                    end
                    else
                    begin
                        gain_next = gain_reg - SUM_W'(ram_rdata);
                    end
                end
                state_next = rsi_pkg::ST_ADD;
            end

            rsi_pkg::ST_ADD:
            begin
                if (ch_reg[CH_W-1])
                begin
                    loss_next = loss_reg + SUM_W'(new_mag);
                end
                else
                begin
                    gain_next = gain_reg + SUM_W'(ch_reg);
                end
                if (IDX_W'(ptr_reg) + IDX_W'(1) >= n_ext)
                begin
                    ptr_next = '0;
                end
                else
                begin
                    ptr_next = ptr_reg + PTR_W'(1);
                end
                if (seen_ext <= n_ext)
                begin
                    seen_next = seen_reg + SEEN_W'(1);
                end
                state_next = rsi_pkg::ST_CHECK;
            end

            rsi_pkg::ST_CHECK:
            begin
                if (seen_ext <= n_ext)
                begin
                    state_next = rsi_pkg::ST_IDLE;
                end
                else if (loss_reg == '0)
                begin
                    quo_next   = rsi_pkg::NO_LOSS_RSI;
                    nl_next    = 1'b1;
                    state_next = rsi_pkg::ST_FINISH;
                end
                else
                begin
                    div_next   = gain_reg + loss_reg;
                    nl_next    = 1'b0;
                    state_next = rsi_pkg::ST_PROD1;
                end
            end

            // Scale by 100 in Q7.16 with shifts and adds
            rsi_pkg::ST_PROD1:
            begin
                prod_next  = (PROD_W'(gain_reg) << rsi_pkg::SCALE_SH_A)
                           + (PROD_W'(gain_reg) << rsi_pkg::SCALE_SH_B);
                state_next = rsi_pkg::ST_PROD2;
            end

            // Upper part of the product is below the divisor since gains <= total
            rsi_pkg::ST_PROD2:
            begin
                rem_next   = prod_full[PROD_W-1:RSI_W];
                low_next   = prod_full[RSI_W-1:0];
                quo_next   = '0;
                cnt_next   = '0;
                state_next = rsi_pkg::ST_DIV;
            end

            rsi_pkg::ST_DIV:
            begin
                if (div_ge)
                begin
                    rem_next = SUM_W'(div_shift - {1'b0, div_reg});
                end
                else
                begin
                    rem_next = div_shift[SUM_W-1:0];
                end
                low_next = {low_reg[RSI_W-2:0], 1'b0};
                quo_next = {quo_reg[RSI_W-2:0], div_ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(RSI_W - 1))
                begin
                    state_next = rsi_pkg::ST_FINISH;
                end
            end

            // Hold until the output register is free
            rsi_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    rsi_value_next = quo_reg;
                    no_losses_next = nl_reg;
                    state_next     = rsi_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rsi_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rsi_pkg::ST_IDLE;
            win_reg       <= rsi_pkg::WINDOW_RESET;
            prev_reg      <= '0;
            gain_reg      <= '0;
            loss_reg      <= '0;
            seen_reg      <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            win_reg       <= win_next;
            prev_reg      <= prev_next;
            gain_reg      <= gain_next;
            loss_reg      <= loss_next;
            seen_reg      <= seen_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg        <= ch_next;
        div_reg       <= div_next;
        prod_reg      <= prod_next;
        rem_reg       <= rem_next;
        low_reg       <= low_next;
        quo_reg       <= quo_next;
        nl_reg        <= nl_next;
        cnt_reg       <= cnt_next;
        rsi_value_reg <= rsi_value_next;
        no_losses_reg <= no_losses_next;
    end

    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_acc |=> (seen_reg == '0) && (gain_reg == '0) && (loss_reg == '0))
        else $error("window write did not clear history");

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_ext <= n_ext + IDX_W'(1))
        else $error("sample count beyond window plus one");

    a_no_loss_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rsi_pkg::ST_CHECK && seen_ext > n_ext && loss_reg == '0)
        |=> (state_reg == rsi_pkg::ST_FINISH) && nl_reg)
        else $error("zero loss sum did not take the fixed-value path");

    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == rsi_pkg::ST_FINISH))
        else $error("result beat raised outside finish");

    a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rsi_pkg::ST_FINISH) |-> (quo_reg <= rsi_pkg::SCALE_Q716))
        else $error("quotient above 100 in Q7.16");

endmodule

[tb/sv/relative_strength_index_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for relative_strength_index_unit: drives price beats, predicts
// RSI beats with an in-bench sliding-window model and compares them. Depends on rsi_pkg and the DUT.
module relative_strength_index_unit_tb;

    localparam int RSI_W = rsi_pkg::RSI_W;
    localparam int WIN_W = rsi_pkg::WIN_W;
    localparam int WINDOW_CAP = 64;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT = 3000;
    localparam logic [63:0] FULL_SCALE = 64'd6553600;
    localparam logic [RSI_W-1:0] FLAT_RSI = RSI_W'((64'd10000 << 16) / 64'd101);

    typedef enum int { TREND_WALK, TREND_UP, TREND_DOWN, TREND_FLAT, TREND_WILD } trend_t;

    typedef struct packed {
        logic [RSI_W-1:0] rsi;
        logic             no_loss;
    } rsi_beat_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [31:0]          price_sample;
    logic                 out_valid;
    logic                 out_ready;
    logic [RSI_W-1:0]     rsi_value;
    logic                 no_losses;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [WIN_W-1:0]     window_length;

    // stimulus side
    logic [31:0]          price_queue[$];
    rsi_beat_t            rsi_expected[$];
    int unsigned          prices_pushed;
    int unsigned          prices_accepted;
    int unsigned          results_checked;
    int unsigned          cfg_beats;
    int unsigned          mismatches;
    int unsigned          stall_cycles;
    int unsigned          sender_idle_pct;
    int unsigned          recv_idle_pct;
    logic                 price_beat;
    logic [31:0]          gen_price;

    // predictor state
    logic [WIN_W-1:0]     win_setting;
    logic [31:0]          last_px;
    logic [32:0]          change_hist[WINDOW_CAP];
    logic [63:0]          up_total;
    logic [63:0]          down_total;
    int unsigned          px_count;
    int unsigned          hist_slot;

    relative_strength_index_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .price_sample  (price_sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .rsi_value     (rsi_value),
        .no_losses     (no_losses),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .window_length (window_length)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic void clear_history();
        last_px = '0;
        up_total = '0;
        down_total = '0;
        px_count = 0;
        hist_slot = 0;
        for (int i = 0; i < WINDOW_CAP; i++)
            change_hist[i] = '0;
    endfunction

    function automatic void fold_change(input logic [32:0] delta, input bit add);
        logic [32:0] mag;
        if (delta[32])
        begin
            mag = -delta;
            if (add)
                down_total += 64'(mag);
            else
                down_total -= 64'(mag);
        end
        else
        begin
            if (add)
                up_total += 64'(delta);
            else
                up_total -= 64'(delta);
        end
    endfunction

    function automatic void predict_rsi(input logic [31:0] price);
        int unsigned n;
        logic [32:0] delta;
        logic [127:0] scaled;
        logic [127:0] quot;
        rsi_beat_t beat;
        n = (win_setting == 0) ? 1 : ((win_setting > WINDOW_CAP) ? WINDOW_CAP : win_setting);
        if (px_count == 0)
        begin
            last_px = price;
            px_count = 1;
            return;
        end
        delta = {1'b0, price} - {1'b0, last_px};
        last_px = price;
        if (hist_slot >= n)
            hist_slot = 0;
        // drop the oldest change once the window is full
        if (px_count - 1 >= n)
            fold_change(change_hist[hist_slot], 1'b0);
        change_hist[hist_slot] = delta;
        fold_change(delta, 1'b1);
        hist_slot = (hist_slot + 1 >= n) ? 0 : hist_slot + 1;
        if (px_count <= n)
            px_count++;
        if (px_count <= n)
            return;
        if (down_total == 0)
        begin
            beat.rsi = FLAT_RSI;
            beat.no_loss = 1'b1;
        end
        else
        begin
            scaled = 128'(up_total) * 128'(FULL_SCALE);
            quot = scaled / 128'(up_total + down_total);
            beat.rsi = quot[RSI_W-1:0];
            beat.no_loss = 1'b0;
        end
        rsi_expected = {rsi_expected, beat};
    endfunction

    function automatic logic [31:0] next_price(input trend_t trend);
        logic [31:0] step;
        int unsigned pick;
        step = 32'($urandom_range(0, 1 << 16)) << $urandom_range(0, 8);
        pick = $urandom_range(99);
        case (trend)
            TREND_UP:   return gen_price + step;
            TREND_DOWN: return gen_price - step;
            TREND_FLAT: return gen_price;
            TREND_WILD: return $urandom;
            default:
            begin
                if (pick < 45)
                    return gen_price + step;
                else if (pick < 90)
                    return gen_price - step;
                else if (pick < 94)
                    return gen_price;
                else if (pick < 96)
                    return 32'h0000_0000;
                else if (pick < 98)
                    return 32'hFFFF_FFFF;
                else
                    return $urandom;
            end
        endcase
    endfunction

    task automatic push_price(input logic [31:0] p);
        price_queue = {price_queue, p};
        prices_pushed++;
    endtask

    // hold until every price is taken and every result has come back
    task automatic wait_drained();
        while (prices_accepted != prices_pushed || rsi_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] len);
        int unsigned seen;
        seen = cfg_beats;
        @(negedge clk);
        cfg_valid <= 1'b1;
        window_length <= len;
        while (cfg_beats == seen)
            @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random_phase(input logic [WIN_W-1:0] len, input bit pause_midway);
        int unsigned n;
        int unsigned count;
        int unsigned pick;
        trend_t trend;
        n = (len == 0) ? 1 : ((len > WINDOW_CAP) ? WINDOW_CAP : len);
        count = n + 31;
        trend = TREND_WALK;
        wait_idle();
        write_window(len);
        for (int i = 0; i < count; i++)
        begin
            // switch trend in short runs so that all-gain and all-loss windows occur
            if (i % 8 == 0)
            begin
                pick = $urandom_range(99);
                if (pick < 60)
                    trend = TREND_WALK;
                else if (pick < 75)
                    trend = TREND_UP;
                else if (pick < 90)
                    trend = TREND_DOWN;
                else if (pick < 95)
                    trend = TREND_FLAT;
                else
                    trend = TREND_WILD;
            end
            gen_price = next_price(trend);
            push_price(gen_price);
            if (pause_midway && i == count / 2)
                wait_drained();
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || price_beat)
            begin
                if (price_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    in_valid <= 1'b1;
                    price_sample <= price_queue.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            price_beat <= 1'b0;
            stall_cycles <= 0;
        end
        else
        begin
            price_beat <= in_valid && in_ready;
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;

            if (out_valid && out_ready)
            begin
                if (rsi_expected.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result rsi=%0d no_losses=%0b",
                                              rsi_value, no_losses));
                end
                else
                begin
                    rsi_beat_t want;
                    want = rsi_expected.pop_front();
                    if (rsi_value !== want.rsi)
                        report_mismatch($sformatf("rsi_value got %0d want %0d",
                                                  rsi_value, want.rsi));
                    if (no_losses !== want.no_loss)
                        report_mismatch($sformatf("no_losses got %0b want %0b",
                                                  no_losses, want.no_loss));
                end
                results_checked++;
            end
            if (cfg_valid && cfg_ready)
            begin
                win_setting = window_length;
                clear_history();
                cfg_beats++;
            end
            if (in_valid && in_ready)
            begin
                predict_rsi(price_sample);
                prices_accepted++;
            end
        end
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("relative_strength_index_unit test failed");
        $finish;
    end

    initial
    begin
        logic [31:0] reset_window_prices[16];
        logic [31:0] unit_window_prices[6];
        rst_n = 1'b0;
        in_valid = 1'b0;
        price_sample = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        window_length = '0;
        prices_pushed = 0;
        prices_accepted = 0;
        results_checked = 0;
        cfg_beats = 0;
        mismatches = 0;
        gen_price = 32'h0064_0000;
        win_setting = rsi_pkg::WINDOW_RESET;
        clear_history();
        sender_idle_pct = 32;
        recv_idle_pct = 49;
        reset_window_prices = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000,
                                32'h7FFF_FFFF, 32'h0001_0000, 32'h0001_0000, 32'hAAAA_AAAA,
                                32'h5555_5555, 32'h0000_0001, 32'hFFFF_FFFE, 32'h1234_5678,
                                32'h1234_5679, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000};
        // window 0 acts as 1: flat, pure gain, pure loss, then the full-range swings
        unit_window_prices = '{32'h0000_0100, 32'h0000_0100, 32'h0000_0200, 32'h0000_0180,
                               32'hFFFF_FFFF, 32'h0000_0000};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset window of 14 first, with no register write
        foreach (reset_window_prices[i])
            push_price(reset_window_prices[i]);
        wait_idle();
        write_window(7'd0);
        foreach (unit_window_prices[i])
            push_price(unit_window_prices[i]);

        run_random_phase(7'd1, 1'b0);
        run_random_phase(7'd64, 1'b0);
        run_random_phase(7'd127, 1'b0);
        run_random_phase(7'd5, 1'b1);
        sender_idle_pct = 49;
        recv_idle_pct = 32;
        run_random_phase(7'd0, 1'b0);
        run_random_phase(7'd2, 1'b0);
        run_random_phase(WIN_W'($urandom_range(3, 63)), 1'b0);
        sender_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(7'd100, 1'b0);
        run_random_phase(WIN_W'($urandom_range(3, 63)), 1'b0);
        run_random_phase(7'd14, 1'b0);

        wait_idle();
        if (rsi_expected.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", rsi_expected.size()));
        $display("Covered %0d prices and %0d RSI results over %0d window settings,",
                 prices_accepted, results_checked, cfg_beats + 1);
        $display("including windows 0, 1, 2, 64 and saturating values; %0d mismatches.",
                 mismatches);
        if (mismatches == 0)
            $display("relative_strength_index_unit test passed");
        else
            $display("relative_strength_index_unit test failed");
        $finish;
    end

endmodule
